// File: rtl/moving_inversion_chunk_sweep_macros.svh
// assertion macros for the chunk sweep engine
// uses clk and rst_n of the module in which the macro is expanded
`ifndef MOVING_INVERSION_CHUNK_SWEEP_MACROS_SVH
`define MOVING_INVERSION_CHUNK_SWEEP_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define MICS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MICS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MICS_ASSERT(lbl, prop, msg)
`define MICS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/mics_pkg.sv
// shared constants of the moving inversion chunk sweep engine
// no dependencies
`default_nettype none

package mics_pkg;

  // default geometry of the store
  localparam int CHUNK_WORDS_DEF = 256;
  localparam int NUM_CHUNKS_DEF  = 16;

  // pattern and register reset values
  localparam logic [31:0] PATTERN_MASK      = 32'h5a5a_5a5a;
  localparam logic [31:0] WINDOW_BASE_RESET = 32'h1500_0000;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_AVAIL = 2'd1;
  localparam int CHUNKS_AVAIL_W = 5;

  // operation codes, the unused code behaves as verify
  localparam logic [1:0] FUNC_WRITE      = 2'd0;
  localparam logic [1:0] FUNC_VERIFY_INV = 2'd1;
  localparam logic [1:0] FUNC_VERIFY     = 2'd2;

endpackage

`default_nettype wire

// File: rtl/mics_store.sv
// test store: single write port, single registered read port
// no package dependencies
`default_nettype none

module mics_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [31:0]       wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [31:0]       rd_data
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/moving_inversion_chunk_sweep.sv
// Moving inversion self-test engine. Each request names an operation and a
// chunk; the engine sweeps that chunk of its internal store and returns one
// result. After reset a clearing pass zeroes the store, one word a cycle,
// during which no request is taken (configuration writes are). A write request
// makes one store write per word. A verify request gives each word a store
// read and then a compare with optional write-back, and the read of the next
// word does not start until the compare is done. A mismatch ends the sweep
// early; a refused chunk goes straight to its result without a sweep. One
// request is in work at a time; a finished result waits in the output register
// while the next request is taken.
// depends on mics_pkg, mics_store and moving_inversion_chunk_sweep_macros.svh
`default_nettype none
`include "moving_inversion_chunk_sweep_macros.svh"

module moving_inversion_chunk_sweep #(
  parameter int CHUNK_WORDS = mics_pkg::CHUNK_WORDS_DEF,
  parameter int NUM_CHUNKS  = mics_pkg::NUM_CHUNKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_func,
  input  wire logic [7:0]                     in_chunk_index,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_ok,
  output logic [31:0]                         out_fault_addr,
  // configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mics_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  import mics_pkg::*;

  localparam int STORE_WORDS = CHUNK_WORDS * NUM_CHUNKS;
  localparam int SLOT_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CW_W        = (CHUNK_WORDS > 1) ? $clog2(CHUNK_WORDS) : 1;
  localparam logic [8:0]        NUM_CHUNKS_9 = 9'(NUM_CHUNKS);
  localparam logic [CW_W-1:0]   LAST_WORD    = CW_W'(CHUNK_WORDS - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(STORE_WORDS - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic [CW_W-1:0]           cnt_r, cnt_nxt;
  logic [31:0]               addr_r, addr_nxt;
  logic [1:0]                func_r, func_nxt;
  logic                      res_ok_r, res_ok_nxt;
  logic [31:0]               res_fail_r, res_fail_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_ok_r, out_ok_nxt;
  logic [31:0]               out_fail_r, out_fail_nxt;
  logic [31:0]               cfg_base_r;
  logic [CHUNKS_AVAIL_W-1:0] cfg_chunks_r;

  logic              in_accept;
  logic              refused;
  logic [SLOT_W-1:0] first_slot;
  logic [31:0]       pat;
  logic [31:0]       expect_word;
  logic              match;
  logic              mem_we;
  logic [31:0]       mem_wdata;
  logic              mem_re;
  logic [31:0]       mem_rdata;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r   <= WINDOW_BASE_RESET;
      cfg_chunks_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_BASE:  cfg_base_r   <= cfg_data;
        CFG_CHUNKS_AVAIL: cfg_chunks_r <= cfg_data[CHUNKS_AVAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode
  assign in_ready   = (state_r == ST_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign refused    = ({1'b0, in_chunk_index} >= 9'(cfg_chunks_r)) ||
                      ({1'b0, in_chunk_index} >= NUM_CHUNKS_9);
  assign first_slot = SLOT_W'(32'(in_chunk_index) * CHUNK_WORDS);

  // pattern and compare for the word in flight
  assign pat         = addr_r ^ PATTERN_MASK;
  assign expect_word = (func_r == FUNC_VERIFY_INV) ? pat : ~pat;
  assign match       = (mem_rdata == expect_word);

  // store access
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = pat;
      end
      ST_CHECK: begin
        mem_we    = match && (func_r == FUNC_VERIFY_INV);
        mem_wdata = ~pat;
      end
      default: ;
    endcase
  end

  assign mem_re = (state_r == ST_READ);

  mics_store #(
    .DEPTH  (STORE_WORDS),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (slot_r),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (slot_r),
    .rd_data (mem_rdata)
  );

  // sweep sequencer
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    func_nxt      = func_r;
    res_ok_nxt    = res_ok_r;
    res_fail_nxt  = res_fail_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_fail_nxt  = out_fail_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        slot_nxt = slot_r + 1'b1;
        if (slot_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          func_nxt     = in_func;
          slot_nxt     = first_slot;
          cnt_nxt      = '0;
          addr_nxt     = cfg_base_r + 32'({first_slot, 2'b00});
          res_ok_nxt   = 1'b0;
          res_fail_nxt = '0;
          if (refused) begin
            state_nxt = ST_FINISH;
          end else if (in_func == FUNC_WRITE) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!match) begin
          res_ok_nxt   = 1'b0;
          res_fail_nxt = addr_r;
          state_nxt    = ST_FINISH;
        end else if (cnt_r == LAST_WORD) begin
          res_ok_nxt = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          slot_nxt  = slot_r + 1'b1;
          addr_nxt  = addr_r + 32'd4;
          state_nxt = ST_READ;
        end
      end
      ST_WRITE: begin
        if (cnt_r == LAST_WORD) begin
          res_ok_nxt = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          slot_nxt = slot_r + 1'b1;
          addr_nxt = addr_r + 32'd4;
        end
      end
      ST_FINISH: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_fail_nxt  = res_fail_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    func_r     <= func_nxt;
    res_ok_r   <= res_ok_nxt;
    res_fail_r <= res_fail_nxt;
    out_ok_r   <= out_ok_nxt;
    out_fail_r <= out_fail_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_fault_addr = out_fail_r;

  // checks
  `MICS_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> state_r == ST_CLEAR,
    "reset did not start the clearing pass")
  `MICS_ASSERT(a_check_write_func, (state_r == ST_CHECK && mem_we) |->
    func_r == FUNC_VERIFY_INV, "write-back during check outside verify-invert")
  `MICS_ASSERT(a_ok_no_addr, out_valid_r && out_ok_r |-> out_fail_r == 32'd0,
    "passing result carries a failure address")
  `MICS_ASSERT(a_result_held, out_valid_r && !out_ready |=>
    out_valid_r && $stable(out_ok_r) && $stable(out_fail_r),
    "pending result lost or changed")
  `MICS_ASSERT(a_read_then_check, state_r == ST_READ |=> state_r == ST_CHECK,
    "store read not followed by its compare")

endmodule

`default_nettype wire

// File: dv/moving_inversion_chunk_sweep_tb.sv
// self-checking testbench for the moving inversion chunk sweep engine
// keeps its own copy of the test store and predicts every sweep result
// depends on mics_pkg and the moving_inversion_chunk_sweep rtl
`default_nettype none

module moving_inversion_chunk_sweep_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mics_pkg::*;

  // the spare operation code sweeps like a plain verify
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int STORE_WORDS  = NUM_CHUNKS_DEF * CHUNK_WORDS_DEF;
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_SWEEPS = 1100;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] chunk;
  } sweep_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] fault_addr;
  } sweep_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = FUNC_WRITE;
  logic [7:0] in_chunk_index = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [31:0] out_fault_addr;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_BASE;
  logic [31:0] cfg_data = 32'd0;

  // predictor state: shadow store and register copies
  logic [31:0] test_mem [STORE_WORDS];
  logic [31:0] base_model = WINDOW_BASE_RESET;
  logic [CHUNKS_AVAIL_W-1:0] avail_model = '0;

  sweep_req_t pending_sweeps[$];
  sweep_res_t expected_results[$];
  sweep_req_t cur_req;

  logic req_taken = 1'b0;
  bit idle_en = 1'b1;
  int req_gap = 0;
  int ready_stall = 0;
  int idle_cycles = 0;
  int errors = 0;
  int sweeps_queued = 0;
  int results_seen = 0;
  int passed_cnt = 0;
  int miscompare_cnt = 0;
  int refused_cnt = 0;
  int settings_cnt = 0;

  moving_inversion_chunk_sweep u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_chunk_index (in_chunk_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_fault_addr (out_fault_addr),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // gap length: mostly none, some short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 60);
  endfunction

  // sweep one chunk of the shadow store, as the engine does
  function automatic sweep_res_t predict_sweep(input logic [1:0] op, input logic [7:0] chunk);
    sweep_res_t res;
    logic [31:0] slot;
    logic [31:0] addr;
    logic [31:0] pat;
    logic [31:0] want;
    int i;
    res.ok = 1'b0;
    res.fault_addr = '0;
    if (chunk >= avail_model || chunk >= NUM_CHUNKS_DEF) begin
      refused_cnt++;
      return res;
    end
    for (i = 0; i < CHUNK_WORDS_DEF; i++) begin
      slot = chunk * CHUNK_WORDS_DEF + i;
      addr = base_model + (slot << 2);
      pat = addr ^ PATTERN_MASK;
      if (op == FUNC_WRITE) begin
        test_mem[slot] = pat;
      end else begin
        want = (op == FUNC_VERIFY_INV) ? pat : ~pat;
        if (test_mem[slot] != want) begin
          res.fault_addr = addr;
          miscompare_cnt++;
          return res;
        end
        if (op == FUNC_VERIFY_INV) test_mem[slot] = ~pat;
      end
    end
    res.ok = 1'b1;
    passed_cnt++;
    return res;
  endfunction

  task automatic queue_sweep(input logic [1:0] op, input logic [7:0] chunk);
    sweep_req_t r;
    r.func = op;
    r.chunk = chunk;
    pending_sweeps.push_back(r);
    sweeps_queued++;
  endtask

  // register write over the config channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // every queued request has returned its result
  task automatic wait_quiet();
    do @(negedge clk); while (results_seen < sweeps_queued);
  endtask

  task automatic set_window(input logic [31:0] base, input logic [4:0] avail);
    write_reg(CFG_WINDOW_BASE, base);
    write_reg(CFG_CHUNKS_AVAIL, {27'd0, avail});
    settings_cnt++;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_gap > 0) begin
        in_valid <= 1'b0;
        req_gap--;
      end else if (pending_sweeps.size() != 0) begin
        cur_req = pending_sweeps.pop_front();
        in_valid <= 1'b1;
        in_func <= cur_req.func;
        in_chunk_index <= cur_req.chunk;
        req_gap = draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (ready_stall > 0) begin
      out_ready <= 1'b0;
      ready_stall--;
    end else begin
      out_ready <= 1'b1;
      ready_stall = draw_gap();
    end
  end

  // monitor: register copies, prediction, result check, watchdog
  always @(posedge clk) begin
    sweep_res_t exp_res;
    req_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_BASE:  base_model = cfg_data;
          CFG_CHUNKS_AVAIL: avail_model = cfg_data[CHUNKS_AVAIL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_sweep(in_func, in_chunk_index));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result ok=%0b fault_addr=%h",
                   $time, out_ok, out_fault_addr);
        end else begin
          exp_res = expected_results.pop_front();
          results_seen++;
          if (out_ok !== exp_res.ok) begin
            errors++;
            $display("%0t ns: ok mismatch, expected %0b actual %0b",
                     $time, exp_res.ok, out_ok);
          end
          if (out_fault_addr !== exp_res.fault_addr) begin
            errors++;
            $display("%0t ns: fault_addr mismatch, expected %h actual %h",
                     $time, exp_res.fault_addr, out_fault_addr);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no request moved for %0d cycles", $time, idle_cycles);
        $display("%0d of %0d sweeps checked before the stall",
                 results_seen, sweeps_queued);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int random_sweeps;
    int phase_len;
    int n;
    int avail;
    int chunk;
    logic [31:0] base;
    foreach (test_mem[k]) test_mem[k] = '0;
    base = WINDOW_BASE_RESET;
    random_sweeps = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings refuse every chunk
    queue_sweep(FUNC_WRITE, 8'd0);
    queue_sweep(FUNC_VERIFY_INV, 8'd255);
    wait_quiet();

    // window at zero: a miscompare on the first word reports address 0
    set_window(32'd0, 5'd16);
    queue_sweep(FUNC_VERIFY, 8'd0);
    queue_sweep(FUNC_WRITE, 8'd0);
    queue_sweep(FUNC_VERIFY_INV, 8'd0);
    queue_sweep(FUNC_VERIFY, 8'd0);
    queue_sweep(FUNC_SPARE, 8'd0);
    queue_sweep(FUNC_VERIFY_INV, 8'd0);
    queue_sweep(FUNC_WRITE, 8'd15);
    queue_sweep(FUNC_VERIFY_INV, 8'd15);
    queue_sweep(FUNC_SPARE, 8'd15);
    queue_sweep(FUNC_WRITE, 8'd16);
    queue_sweep(FUNC_VERIFY, 8'd255);
    wait_quiet();

    // zero pattern on word 0 of chunk 4: verify-invert passes one word, then miscompares
    set_window(PATTERN_MASK - 32'h1000, 5'd5);
    queue_sweep(FUNC_VERIFY_INV, 8'd4);
    queue_sweep(FUNC_VERIFY, 8'd4);
    queue_sweep(FUNC_VERIFY_INV, 8'd5);
    wait_quiet();

    // top of the address space, single chunk backed
    set_window(32'hffff_ffff, 5'd1);
    queue_sweep(FUNC_WRITE, 8'd0);
    queue_sweep(FUNC_VERIFY_INV, 8'd0);
    queue_sweep(FUNC_VERIFY, 8'd0);
    queue_sweep(FUNC_WRITE, 8'd1);
    wait_quiet();
    base = 32'hffff_ffff;

    // random phases: mostly write / verify-invert / verify runs, some noise
    while (random_sweeps < RANDOM_SWEEPS) begin
      case ($urandom_range(0, 9))
        0, 1: base = $urandom;
        2: begin
          case ($urandom_range(0, 4))
            0: base = 32'd0;
            1: base = 32'hffff_ffff;
            2: base = 32'hffff_fe00;
            3: base = WINDOW_BASE_RESET;
            default: base = 32'hffff_f000;
          endcase
        end
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: avail = 0;
        1: avail = 1;
        2, 3: avail = $urandom_range(0, 16);
        default: avail = 16;
      endcase
      idle_en = ($urandom_range(0, 3) != 0);
      set_window(base, avail[4:0]);
      phase_len = $urandom_range(60, 120);
      n = 0;
      while (n < phase_len) begin
        if (avail > 0 && $urandom_range(0, 9) < 7) begin
          chunk = $urandom_range(0, avail - 1);
          if ($urandom_range(0, 4) != 0) begin
            queue_sweep(FUNC_WRITE, chunk[7:0]);
            n++;
          end
          queue_sweep(FUNC_VERIFY_INV, chunk[7:0]);
          queue_sweep($urandom_range(0, 1) ? FUNC_VERIFY : FUNC_SPARE, chunk[7:0]);
          n += 2;
          if ($urandom_range(0, 3) == 0) begin
            queue_sweep(FUNC_VERIFY_INV, chunk[7:0]);
            n++;
          end
        end else begin
          chunk = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 16);
          queue_sweep(2'($urandom_range(0, 3)), chunk[7:0]);
          n++;
        end
      end
      random_sweeps += n;
      wait_quiet();
    end

    // let any stray result show up
    idle_en = 1'b1;
    repeat (600) @(negedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived", $time, expected_results.size());
    end

    $display("%0d sweeps over %0d register settings, %0d results checked",
             sweeps_queued, settings_cnt, results_seen);
    $display("%0d held, %0d miscompared, %0d refused, %0d errors",
             passed_cnt, miscompare_cnt, refused_cnt, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: moving_inversion_chunk_sweep.f
+incdir+rtl
rtl/mics_pkg.sv
rtl/mics_store.sv
rtl/moving_inversion_chunk_sweep.sv
dv/moving_inversion_chunk_sweep_tb.sv
